FILE: design/ubt_pkg.sv
package ubt_pkg;

  localparam int VALUE_W = 48;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;

  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_DEL_VAL  = 2'd1;
  localparam logic [1:0] CMD_DEL_SLOT = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_DEL_VAL,
    OP_DEL_SLOT,
    OP_BAD
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_NOT_FOUND,
    ST_BAD_INDEX
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_COPY,
    S_RESULT
  } bk_state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [VALUE_W-1:0] item_value;
    logic [SLOT_W-1:0]  slot_index;
  } ubt_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;
    logic [SLOT_W-1:0]  slot_used;
  } ubt_out_t;

  // decoded command between front and back
  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
    logic [SLOT_W-1:0]  slot;
  } ubt_cmd_t;

endpackage

FILE: design/ubt_ram.sv
module ubt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/ubt_fifo.sv
module ubt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] buffer [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [NW-1:0]    used;
  logic             do_push;
  logic             do_pop;

  assign full    = (used == NW'(DEPTH));
  assign empty   = (used == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = buffer[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      used <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        used <= used + NW'(1);
      end else if (do_pop && !do_push) begin
        used <= used - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buffer[wptr] <= wdata;
    end
  end

endmodule

FILE: design/ubt_front.sv
module ubt_front
  import ubt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  ubt_in_t  req,
  output logic     full,
  input  logic     q_pop,
  output ubt_cmd_t q_cmd,
  output logic     q_empty
);

  ubt_cmd_t dec;
  logic [$bits(ubt_cmd_t)-1:0] q_data;

  always_comb begin
    dec.value = req.item_value;
    dec.slot  = req.slot_index;
    case (req.cmd)
      CMD_ADD:      dec.op = OP_ADD;
      CMD_DEL_VAL:  dec.op = OP_DEL_VAL;
      CMD_DEL_SLOT: dec.op = OP_DEL_SLOT;
      default:      dec.op = OP_BAD;
    endcase
  end

  ubt_fifo #(
    .WIDTH($bits(ubt_cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(dec),
    .full (full),
    .pop  (q_pop),
    .rdata(q_data),
    .empty(q_empty)
  );

  assign q_cmd = ubt_cmd_t'(q_data);

endmodule

FILE: design/ubt_back.sv
module ubt_back
  import ubt_pkg::*;
#(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 48
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  input  ubt_cmd_t q_cmd,
  output logic     q_pop,
  input  logic     res_full,
  output logic     res_push,
  output ubt_out_t res
);

  localparam int SW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int UW = (AW > SLOT_W) ? AW : SLOT_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  bk_state_t     state, state_next;
  logic [CW-1:0] count, count_next;
  logic [SW-1:0] val, val_next;
  logic [AW-1:0] target, target_next;
  logic [AW-1:0] chk, chk_next;
  logic [AW-1:0] used, used_next;
  status_t       st, st_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;

  logic [CW-1:0] last;
  logic [XW-1:0] idx_x;
  logic [XW-1:0] count_x;
  logic [EW-1:0] count_e;
  logic [UW-1:0] used_e;

  assign last    = count - CW'(1);
  assign idx_x   = XW'(q_cmd.slot);
  assign count_x = XW'(count);
  assign count_e = EW'(count);
  assign used_e  = UW'(used);

  assign res.status      = st;
  assign res.entry_count = count_e[COUNT_W-1:0];
  assign res.slot_used   = used_e[SLOT_W-1:0];

  ubt_ram #(
    .WIDTH(SW),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    val    <= val_next;
    target <= target_next;
    chk    <= chk_next;
    used   <= used_next;
    st     <= st_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    val_next    = val;
    target_next = target;
    chk_next    = chk;
    used_next   = used;
    st_next     = st;
    q_pop       = 1'b0;
    res_push    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = count[AW-1:0];
    ram_wdata   = q_cmd.value[SW-1:0];
    ram_re      = 1'b0;
    ram_raddr   = '0;

    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          val_next  = q_cmd.value[SW-1:0];
          used_next = '0;
          case (q_cmd.op)
            OP_ADD: begin
              if (count >= CAP_C) begin
                st_next = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                used_next  = count[AW-1:0];
                count_next = count + CW'(1);
                st_next    = ST_OK;
              end
              state_next = S_RESULT;
            end
            OP_DEL_VAL: begin
              if (count == '0) begin
                st_next    = ST_NOT_FOUND;
                state_next = S_RESULT;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                chk_next   = '0;
                state_next = S_SCAN;
              end
            end
            OP_DEL_SLOT: begin
              if (idx_x >= count_x) begin
                st_next    = ST_BAD_INDEX;
                state_next = S_RESULT;
              end else begin
                target_next = idx_x[AW-1:0];
                state_next  = S_MOVE;
              end
            end
            default: begin
              st_next    = ST_BAD_INDEX;
              state_next = S_RESULT;
            end
          endcase
        end
      end
      S_SCAN: begin
        // one entry compared per cycle, next read issued alongside
        if (ram_rdata == val) begin
          target_next = chk;
          state_next  = S_MOVE;
        end else if (CW'(chk) == last) begin
          st_next    = ST_NOT_FOUND;
          state_next = S_RESULT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = chk + AW'(1);
          chk_next  = chk + AW'(1);
        end
      end
      S_MOVE: begin
        if (CW'(target) < last) begin
          ram_re     = 1'b1;
          ram_raddr  = last[AW-1:0];
          state_next = S_COPY;
        end else begin
          // removing the last slot: only the count drops
          count_next = last;
          used_next  = target;
          st_next    = ST_OK;
          state_next = S_RESULT;
        end
      end
      S_COPY: begin
        ram_we     = 1'b1;
        ram_waddr  = target;
        ram_wdata  = ram_rdata;
        count_next = last;
        used_next  = target;
        st_next    = ST_OK;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/unordered_bag_table_unit.sv
// command flow from push to result transfer: add and rejected commands go idle, result;
// remove by slot: idle, move, copy, result, or no copy when the slot is the last entry;
// remove by value scans from slot 0 to the match, then moves like remove by slot, and scans
// every entry before the result when nothing matches; one command executes at a time, and
// the value search reads the entry ram one slot per cycle
// rst (synchronous) empties both queues and zeroes the count; the entry ram is not cleared
module unordered_bag_table_unit
  import ubt_pkg::*;
#(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 48
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  ubt_in_t  req,
  output logic     full,
  input  logic     pop,
  output ubt_out_t rsp,
  output logic     empty
);

  logic     q_pop;
  logic     q_empty;
  ubt_cmd_t q_cmd;
  logic     res_push;
  logic     res_full;
  ubt_out_t res;
  logic [$bits(ubt_out_t)-1:0] rsp_data;

  ubt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .req    (req),
    .full   (full),
    .q_pop  (q_pop),
    .q_cmd  (q_cmd),
    .q_empty(q_empty)
  );

  ubt_back #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .res_full(res_full),
    .res_push(res_push),
    .res     (res)
  );

  ubt_fifo #(
    .WIDTH($bits(ubt_out_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (pop),
    .rdata(rsp_data),
    .empty(empty)
  );

  assign rsp = ubt_out_t'(rsp_data);

endmodule
